// ===== sv/ccid_pkg.sv =====
// shared types, codes and helpers of the ccid reader command sequencer
// used by ccid_ctrl, ccid_dp and ccid_reader_command_sequencer
`default_nettype none

package ccid_pkg;

  localparam int LenW       = 13;
  localparam int MaxPayload = 4096;
  localparam int HdrLen     = 10;
  localparam int DivSteps   = LenW;
  localparam int CntW       = $clog2(DivSteps);

  // event codes of an input item
  localparam logic [2:0] OP_CMD     = 3'd0;
  localparam logic [2:0] OP_TX_DONE = 3'd1;
  localparam logic [2:0] OP_ABORT   = 3'd2;
  localparam logic [2:0] OP_RESP    = 3'd3;
  localparam logic [2:0] OP_SUSPEND = 3'd4;

  // result actions
  localparam logic [2:0] ACT_REARM  = 3'd0;
  localparam logic [2:0] ACT_SEND   = 3'd1;
  localparam logic [2:0] ACT_ZLP    = 3'd2;
  localparam logic [2:0] ACT_FWD    = 3'd3;
  localparam logic [2:0] ACT_CANCEL = 3'd4;

  // reply message kinds
  localparam logic [1:0] RT_SLOT   = 2'd0;
  localparam logic [1:0] RT_DATA   = 2'd1;
  localparam logic [1:0] RT_PARAMS = 2'd2;

  // forwarded request kinds
  localparam logic [2:0] RQ_POWER_ON  = 3'd0;
  localparam logic [2:0] RQ_POWER_OFF = 3'd1;
  localparam logic [2:0] RQ_APDU      = 3'd2;
  localparam logic [2:0] RQ_GET       = 3'd3;
  localparam logic [2:0] RQ_SET       = 3'd4;
  localparam logic [2:0] RQ_RESET     = 3'd5;

  // host message types
  localparam logic [7:0] MT_POWER_ON     = 8'h62;
  localparam logic [7:0] MT_POWER_OFF    = 8'h63;
  localparam logic [7:0] MT_SLOT_STATUS  = 8'h65;
  localparam logic [7:0] MT_XFR_BLOCK    = 8'h6F;
  localparam logic [7:0] MT_GET_PARAMS   = 8'h6C;
  localparam logic [7:0] MT_RESET_PARAMS = 8'h6D;
  localparam logic [7:0] MT_SET_PARAMS   = 8'h61;
  localparam logic [7:0] MT_ABORT        = 8'h72;

  localparam logic [7:0] ERR_NONE    = 8'h00;
  localparam logic [7:0] ERR_HW      = 8'hFB;
  localparam logic [7:0] ERR_ABORTED = 8'hFF;

  localparam logic CS_OK   = 1'b0;
  localparam logic CS_FAIL = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_HW = 2'd1;

  localparam logic [0:0] CFG_PACKET_SIZE  = 1'd0;
  localparam logic [0:0] CFG_ICC_PRESENCE = 1'd1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CARD = 2'd1,
    PH_TX   = 2'd2,
    PH_ZLP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_EXEC = 2'd2,
    S_OUT  = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic op_is_tx;
    logic div_last;
    logic has_result;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]      action;
    logic [1:0]      reply_type;
    logic [7:0]      reply_seq;
    logic [7:0]      reply_status;
    logic [7:0]      reply_error;
    logic [LenW-1:0] reply_length;
    logic            reply_protocol;
    logic [2:0]      request_kind;
    logic [7:0]      request_param;
  } result_t;

  function automatic result_t simple_res(input logic [2:0] act);
    result_t r;
    r        = '0;
    r.action = act;
    return r;
  endfunction

  function automatic result_t reply_res(input logic [1:0] rtype, input logic [7:0] seq,
                                        input logic [7:0] err, input logic cs,
                                        input logic [LenW-1:0] len, input logic proto,
                                        input logic [1:0] icc);
    result_t r;
    r                = '0;
    r.action         = ACT_SEND;
    r.reply_type     = rtype;
    r.reply_seq      = seq;
    r.reply_status   = {1'b0, cs, 4'b0000, icc};
    r.reply_error    = err;
    r.reply_length   = len;
    r.reply_protocol = proto;
    return r;
  endfunction

  function automatic result_t fwd_res(input logic [2:0] kind, input logic [7:0] param);
    result_t r;
    r               = '0;
    r.action        = ACT_FWD;
    r.request_kind  = kind;
    r.request_param = param;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ccid_ctrl.sv =====
// controller of the ccid reader command sequencer: item handshake and sequencing
// depends on ccid_pkg
`default_nettype none

module ccid_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire                      out_ready,
  input  wire ccid_pkg::dp_stat_t  stat,
  output ccid_pkg::dp_cmd_t        cmd
);

  ccid_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccid_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccid_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.op_is_tx ? ccid_pkg::S_DIV : ccid_pkg::S_EXEC;
        end
      end
      ccid_pkg::S_DIV: begin
        if (stat.div_last) begin
          state_nxt = ccid_pkg::S_EXEC;
        end
      end
      ccid_pkg::S_EXEC: begin
        state_nxt = stat.has_result ? ccid_pkg::S_OUT : ccid_pkg::S_IDLE;
      end
      ccid_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = ccid_pkg::S_IDLE;
        end
      end
      default: state_nxt = ccid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    case (state_r)
      ccid_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ccid_pkg::S_DIV:  cmd.div_step = 1'b1;
      ccid_pkg::S_EXEC: cmd.exec = 1'b1;
      ccid_pkg::S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ccid_dp.sv =====
// datapath of the ccid reader command sequencer: config, protocol state,
// transmit length remainder unit and result register; depends on ccid_pkg
`default_nettype none

module ccid_dp (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire ccid_pkg::dp_cmd_t       cmd,
  output ccid_pkg::dp_stat_t           stat,
  input  wire                          cfg_valid,
  input  wire [0:0]                    cfg_index,
  input  wire [6:0]                    cfg_data,
  input  wire [2:0]                    in_operation,
  input  wire [7:0]                    in_msg_type,
  input  wire [7:0]                    in_msg_seq,
  input  wire [7:0]                    in_param_byte,
  input  wire [1:0]                    in_response_status,
  input  wire                          in_response_protocol,
  input  wire [ccid_pkg::LenW-1:0]     in_response_length,
  output ccid_pkg::result_t            res
);

  logic [6:0] packet_size_r;
  logic [1:0] icc_presence_r;

  ccid_pkg::phase_t          phase_r, phase_nxt;
  logic                      abort_r, abort_nxt;
  logic [7:0]                cur_seq_r, cur_seq_nxt;
  logic [2:0]                pend_r, pend_nxt;
  logic [ccid_pkg::LenW-1:0] sent_len_r, sent_len_nxt;

  // latched item
  logic [2:0]                op_r;
  logic [7:0]                type_r, seq_r, pb_r;
  logic [1:0]                st_r;
  logic                      proto_r;
  logic [ccid_pkg::LenW-1:0] len_r;

  // remainder unit, one dividend bit per cycle
  logic [ccid_pkg::LenW-1:0] dvd_r;
  logic [6:0]                rem_r;
  logic [ccid_pkg::CntW-1:0] cnt_r;
  logic [7:0]                rem_sh;
  logic [7:0]                rem_step;

  ccid_pkg::result_t         res_r, res_nxt;
  logic                      has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_size_r  <= 7'd64;
      icc_presence_r <= 2'd1;
    end else if (cfg_valid) begin
      if (cfg_index == ccid_pkg::CFG_PACKET_SIZE) begin
        packet_size_r <= cfg_data;
      end else begin
        icc_presence_r <= cfg_data[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ccid_pkg::PH_IDLE;
      abort_r    <= 1'b0;
      cur_seq_r  <= '0;
      pend_r     <= '0;
      sent_len_r <= '0;
    end else if (cmd.exec) begin
      phase_r    <= phase_nxt;
      abort_r    <= abort_nxt;
      cur_seq_r  <= cur_seq_nxt;
      pend_r     <= pend_nxt;
      sent_len_r <= sent_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      type_r  <= in_msg_type;
      seq_r   <= in_msg_seq;
      pb_r    <= in_param_byte;
      st_r    <= in_response_status;
      proto_r <= in_response_protocol;
      len_r   <= in_response_length;
    end
  end

  assign rem_sh   = {rem_r, dvd_r[ccid_pkg::LenW-1]};
  assign rem_step = (rem_sh >= {1'b0, packet_size_r}) ? rem_sh - {1'b0, packet_size_r}
                                                      : rem_sh;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd_r <= sent_len_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[ccid_pkg::LenW-2:0], 1'b0};
      rem_r <= rem_step[6:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_comb begin
    logic [ccid_pkg::LenW-1:0] len_sat;
    logic [7:0]                err;
    logic                      do_reply;
    logic [ccid_pkg::LenW-1:0] rep_len;

    phase_nxt    = phase_r;
    abort_nxt    = abort_r;
    cur_seq_nxt  = cur_seq_r;
    pend_nxt     = pend_r;
    sent_len_nxt = sent_len_r;
    res_nxt      = '0;
    has_res      = 1'b0;
    do_reply     = 1'b0;
    len_sat      = (len_r > ccid_pkg::LenW'(ccid_pkg::MaxPayload))
                   ? ccid_pkg::LenW'(ccid_pkg::MaxPayload) : len_r;
    err          = (st_r == ccid_pkg::ST_HW) ? ccid_pkg::ERR_HW : ccid_pkg::ERR_NONE;

    case (op_r)
      ccid_pkg::OP_CMD: begin
        has_res = 1'b1;
        if (abort_r) begin
          do_reply = 1'b1;
          if (seq_r == cur_seq_r && type_r == ccid_pkg::MT_ABORT) begin
            abort_nxt = 1'b0;
            res_nxt   = ccid_pkg::reply_res(ccid_pkg::RT_SLOT, seq_r, ccid_pkg::ERR_NONE,
                                            ccid_pkg::CS_OK, '0, 1'b0, icc_presence_r);
          end else begin
            res_nxt   = ccid_pkg::reply_res(ccid_pkg::RT_SLOT, seq_r, ccid_pkg::ERR_ABORTED,
                                            ccid_pkg::CS_FAIL, '0, 1'b0, icc_presence_r);
          end
        end else if (phase_r != ccid_pkg::PH_IDLE) begin
          phase_nxt = ccid_pkg::PH_IDLE;
          res_nxt   = ccid_pkg::simple_res(ccid_pkg::ACT_REARM);
        end else begin
          cur_seq_nxt = seq_r;
          phase_nxt   = ccid_pkg::PH_CARD;
          case (type_r)
            ccid_pkg::MT_POWER_ON:     res_nxt = ccid_pkg::fwd_res(ccid_pkg::RQ_POWER_ON, pb_r);
            ccid_pkg::MT_POWER_OFF:    res_nxt = ccid_pkg::fwd_res(ccid_pkg::RQ_POWER_OFF, '0);
            ccid_pkg::MT_XFR_BLOCK:    res_nxt = ccid_pkg::fwd_res(ccid_pkg::RQ_APDU, pb_r);
            ccid_pkg::MT_GET_PARAMS:   res_nxt = ccid_pkg::fwd_res(ccid_pkg::RQ_GET, '0);
            ccid_pkg::MT_SET_PARAMS:   res_nxt = ccid_pkg::fwd_res(ccid_pkg::RQ_SET, pb_r);
            ccid_pkg::MT_RESET_PARAMS: res_nxt = ccid_pkg::fwd_res(ccid_pkg::RQ_RESET, '0);
            ccid_pkg::MT_SLOT_STATUS: begin
              do_reply = 1'b1;
              res_nxt  = ccid_pkg::reply_res(ccid_pkg::RT_SLOT, seq_r, ccid_pkg::ERR_NONE,
                                             ccid_pkg::CS_OK, '0, 1'b0, icc_presence_r);
            end
            default: begin
              // unsupported command: failed status, error byte zero
              do_reply = 1'b1;
              res_nxt  = ccid_pkg::reply_res(ccid_pkg::RT_SLOT, seq_r, ccid_pkg::ERR_NONE,
                                             ccid_pkg::CS_FAIL, '0, 1'b0, icc_presence_r);
            end
          endcase
          if (!do_reply) begin
            pend_nxt = res_nxt.request_kind;
          end
        end
      end
      ccid_pkg::OP_TX_DONE: begin
        has_res = 1'b1;
        if (phase_r == ccid_pkg::PH_TX && packet_size_r != '0 && rem_r == '0) begin
          phase_nxt = ccid_pkg::PH_ZLP;
          res_nxt   = ccid_pkg::simple_res(ccid_pkg::ACT_ZLP);
        end else begin
          phase_nxt = ccid_pkg::PH_IDLE;
          res_nxt   = ccid_pkg::simple_res(ccid_pkg::ACT_REARM);
        end
      end
      ccid_pkg::OP_ABORT: begin
        has_res     = (phase_r == ccid_pkg::PH_CARD);
        res_nxt     = ccid_pkg::simple_res(ccid_pkg::ACT_CANCEL);
        phase_nxt   = ccid_pkg::PH_IDLE;
        abort_nxt   = 1'b1;
        cur_seq_nxt = seq_r;
      end
      ccid_pkg::OP_RESP: begin
        if (!abort_r && phase_r == ccid_pkg::PH_CARD) begin
          has_res  = 1'b1;
          do_reply = 1'b1;
          case (pend_r)
            ccid_pkg::RQ_POWER_OFF: begin
              res_nxt = ccid_pkg::reply_res(ccid_pkg::RT_SLOT, cur_seq_r, ccid_pkg::ERR_NONE,
                                            (st_r != ccid_pkg::ST_OK), '0, 1'b0,
                                            icc_presence_r);
            end
            ccid_pkg::RQ_GET, ccid_pkg::RQ_SET, ccid_pkg::RQ_RESET: begin
              if (st_r != ccid_pkg::ST_OK) begin
                res_nxt = ccid_pkg::reply_res(ccid_pkg::RT_PARAMS, cur_seq_r, err,
                                              ccid_pkg::CS_FAIL, '0, 1'b1, icc_presence_r);
              end else begin
                res_nxt = ccid_pkg::reply_res(ccid_pkg::RT_PARAMS, cur_seq_r,
                                              ccid_pkg::ERR_NONE, ccid_pkg::CS_OK, len_sat,
                                              proto_r, icc_presence_r);
              end
            end
            default: begin
              if (st_r != ccid_pkg::ST_OK) begin
                res_nxt = ccid_pkg::reply_res(ccid_pkg::RT_DATA, cur_seq_r, err,
                                              ccid_pkg::CS_FAIL, '0, 1'b0, icc_presence_r);
              end else begin
                res_nxt = ccid_pkg::reply_res(ccid_pkg::RT_DATA, cur_seq_r,
                                              ccid_pkg::ERR_NONE, ccid_pkg::CS_OK, len_sat,
                                              1'b0, icc_presence_r);
              end
            end
          endcase
        end
      end
      ccid_pkg::OP_SUSPEND: begin
        phase_nxt = ccid_pkg::PH_IDLE;
        abort_nxt = 1'b0;
      end
      default: ;
    endcase

    // every sent message moves to transmitting and records its full length
    rep_len = res_nxt.reply_length;
    if (do_reply) begin
      phase_nxt    = ccid_pkg::PH_TX;
      sent_len_nxt = rep_len + ccid_pkg::LenW'(ccid_pkg::HdrLen);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && has_res) begin
      res_r <= res_nxt;
    end
  end

  assign res             = res_r;
  assign stat.op_is_tx   = (in_operation == ccid_pkg::OP_TX_DONE);
  assign stat.div_last   = (cnt_r == ccid_pkg::CntW'(ccid_pkg::DivSteps - 1));
  assign stat.has_result = has_res;

  // a cancel only goes out for a request still with the card
  a_cancel_from_card: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && has_res && res_nxt.action == ccid_pkg::ACT_CANCEL
    |-> phase_r == ccid_pkg::PH_CARD)
    else $error("cancel issued outside awaiting card");

  a_fwd_sets_card: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && has_res && res_nxt.action == ccid_pkg::ACT_FWD
    |=> phase_r == ccid_pkg::PH_CARD && !abort_r)
    else $error("forwarded request did not enter awaiting card");

  a_send_sets_tx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && has_res && res_nxt.action == ccid_pkg::ACT_SEND
    |=> phase_r == ccid_pkg::PH_TX)
    else $error("sent message did not enter transmitting");

endmodule

`default_nettype wire

// ===== sv/ccid_reader_command_sequencer.sv =====
// top level of the ccid reader command sequencer
// instantiates ccid_ctrl and ccid_dp, depends on ccid_pkg
`default_nettype none

// Handles one CCID bulk-side event per item and returns at most one result item.
// An event is latched, evaluated in the execute state and its result registered;
// a transmit-done event first reduces the transmit length modulo the packet size
// in a remainder unit that retires one length bit per cycle (13 steps).
// The result is held in an output register until taken, and the next item is
// accepted in the cycle after that, or right after evaluation when the event
// gives no result. Configuration writes are taken in any cycle (cfg_ready is
// always high) and are meant for idle periods only.
module ccid_reader_command_sequencer (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [0:0]                    cfg_index,
  input  wire [6:0]                    cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [2:0]                    in_operation,
  input  wire [7:0]                    in_msg_type,
  input  wire [7:0]                    in_msg_seq,
  input  wire [7:0]                    in_param_byte,
  input  wire [1:0]                    in_response_status,
  input  wire                          in_response_protocol,
  input  wire [ccid_pkg::LenW-1:0]     in_response_length,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [2:0]                   out_action,
  output logic [1:0]                   out_reply_type,
  output logic [7:0]                   out_reply_seq,
  output logic [7:0]                   out_reply_status,
  output logic [7:0]                   out_reply_error,
  output logic [ccid_pkg::LenW-1:0]    out_reply_length,
  output logic                         out_reply_protocol,
  output logic [2:0]                   out_request_kind,
  output logic [7:0]                   out_request_param
);

  ccid_pkg::dp_cmd_t  cmd;
  ccid_pkg::dp_stat_t stat;
  ccid_pkg::result_t  res;

  assign cfg_ready = 1'b1;

  ccid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ccid_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_operation         (in_operation),
    .in_msg_type          (in_msg_type),
    .in_msg_seq           (in_msg_seq),
    .in_param_byte        (in_param_byte),
    .in_response_status   (in_response_status),
    .in_response_protocol (in_response_protocol),
    .in_response_length   (in_response_length),
    .res                  (res)
  );

  assign out_action         = res.action;
  assign out_reply_type     = res.reply_type;
  assign out_reply_seq      = res.reply_seq;
  assign out_reply_status   = res.reply_status;
  assign out_reply_error    = res.reply_error;
  assign out_reply_length   = res.reply_length;
  assign out_reply_protocol = res.reply_protocol;
  assign out_request_kind   = res.request_kind;
  assign out_request_param  = res.request_param;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown in the cycle after acceptance");

  a_reply_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ccid_pkg::ACT_SEND
    |-> out_reply_status == '0 && out_reply_length == '0 && out_reply_seq == '0)
    else $error("reply fields set on a non-send action");

  a_request_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ccid_pkg::ACT_FWD
    |-> out_request_kind == '0 && out_request_param == '0)
    else $error("request fields set on a non-forward action");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for ccid_reader_command_sequencer
// drives bulk-side events and checks replies against a built-in predictor
// depends on ccid_pkg and the ccid_reader_command_sequencer rtl
module tb_top;
  import ccid_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS = 140;
  localparam logic [7:0] ERR_UNSUPPORTED = 8'h00;

  typedef struct packed {
    logic [2:0]      op;
    logic [7:0]      mtype;
    logic [7:0]      seq;
    logic [7:0]      param;
    logic [1:0]      st;
    logic            proto;
    logic [LenW-1:0] len;
  } ccid_event_t;

  typedef struct packed {
    ccid_event_t ev;
    logic        typed;
    result_t     want;
  } dir_row_t;

  localparam result_t REARM_ONLY =
    '{ACT_REARM, RT_SLOT, 8'h00, 8'h00, ERR_NONE, 13'd0, 1'b0, 3'd0, 8'h00};
  localparam result_t ZLP_ONLY =
    '{ACT_ZLP, RT_SLOT, 8'h00, 8'h00, ERR_NONE, 13'd0, 1'b0, 3'd0, 8'h00};
  localparam result_t CANCEL_ONLY =
    '{ACT_CANCEL, RT_SLOT, 8'h00, 8'h00, ERR_NONE, 13'd0, 1'b0, 3'd0, 8'h00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  ccid_event_t cur_ev = '0;
  logic row_typed = 1'b0;
  result_t row_want = '0;

  wire cfg_ready, in_ready, out_valid;
  wire [2:0] out_action, out_request_kind;
  wire [1:0] out_reply_type;
  wire [7:0] out_reply_seq, out_reply_status, out_reply_error, out_request_param;
  wire [LenW-1:0] out_reply_length;
  wire out_reply_protocol;

  // predictor state and its copy of the registers
  phase_t      m_phase = PH_IDLE;
  logic        m_aborting = 1'b0;
  logic [7:0]  m_seq = '0;
  logic [2:0]  m_req = '0;
  int          m_sent_len = 0;
  logic [6:0]  m_pkt = 7'd64;
  logic [1:0]  m_icc = 2'd1;

  result_t pending_replies[$];
  dir_row_t dir_tab[$];
  int n_err = 0, n_items = 0, n_eff = 0, n_results = 0;
  int n_zlp = 0, n_cancel = 0, n_settings = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  logic [6:0] cur_pkt = 7'd64;
  bit hold_go = 1'b0, hold_done = 1'b0;

  ccid_reader_command_sequencer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (cur_ev.op),
    .in_msg_type         (cur_ev.mtype),
    .in_msg_seq          (cur_ev.seq),
    .in_param_byte       (cur_ev.param),
    .in_response_status  (cur_ev.st),
    .in_response_protocol(cur_ev.proto),
    .in_response_length  (cur_ev.len),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_action          (out_action),
    .out_reply_type      (out_reply_type),
    .out_reply_seq       (out_reply_seq),
    .out_reply_status    (out_reply_status),
    .out_reply_error     (out_reply_error),
    .out_reply_length    (out_reply_length),
    .out_reply_protocol  (out_reply_protocol),
    .out_request_kind    (out_request_kind),
    .out_request_param   (out_request_param)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic result_t build_msg(input logic [1:0] kind, input logic [7:0] sq,
                                        input logic [7:0] err, input logic cs,
                                        input logic [LenW-1:0] len, input logic proto);
    result_t r;
    r = '0;
    r.action         = ACT_SEND;
    r.reply_type     = kind;
    r.reply_seq      = sq;
    r.reply_status   = (8'(cs) << 6) | 8'(m_icc);
    r.reply_error    = err;
    r.reply_length   = len;
    r.reply_protocol = proto;
    m_sent_len = int'(len) + HdrLen;
    m_phase = PH_TX;
    return r;
  endfunction

  function automatic result_t forward_req(input logic [2:0] kind, input logic [7:0] param);
    result_t r;
    r = '0;
    r.action        = ACT_FWD;
    r.request_kind  = kind;
    r.request_param = param;
    m_req = kind;
    m_phase = PH_CARD;
    return r;
  endfunction

  // returns 1 when the event produces a result item
  function automatic bit bulk_event_reply(input ccid_event_t e, output result_t r);
    logic [LenW-1:0] len;
    logic [7:0] err;
    logic cs;
    r = '0;
    case (e.op)
      OP_CMD: begin
        if (m_aborting) begin
          if (e.seq == m_seq && e.mtype == MT_ABORT) begin
            m_aborting = 1'b0;
            r = build_msg(RT_SLOT, e.seq, ERR_NONE, CS_OK, '0, 1'b0);
          end else begin
            r = build_msg(RT_SLOT, e.seq, ERR_ABORTED, CS_FAIL, '0, 1'b0);
          end
          return 1'b1;
        end
        if (m_phase != PH_IDLE) begin
          m_phase = PH_IDLE;
          r.action = ACT_REARM;
          return 1'b1;
        end
        m_seq = e.seq;
        case (e.mtype)
          MT_POWER_ON:     r = forward_req(RQ_POWER_ON, e.param);
          MT_POWER_OFF:    r = forward_req(RQ_POWER_OFF, 8'h00);
          MT_XFR_BLOCK:    r = forward_req(RQ_APDU, e.param);
          MT_GET_PARAMS:   r = forward_req(RQ_GET, 8'h00);
          MT_SET_PARAMS:   r = forward_req(RQ_SET, e.param);
          MT_RESET_PARAMS: r = forward_req(RQ_RESET, 8'h00);
          MT_SLOT_STATUS:  r = build_msg(RT_SLOT, e.seq, ERR_NONE, CS_OK, '0, 1'b0);
          default:         r = build_msg(RT_SLOT, e.seq, ERR_UNSUPPORTED, CS_FAIL, '0, 1'b0);
        endcase
        return 1'b1;
      end
      OP_TX_DONE: begin
        if (m_phase == PH_TX && m_pkt != 0 && (m_sent_len % int'(m_pkt)) == 0) begin
          m_phase = PH_ZLP;
          r.action = ACT_ZLP;
        end else begin
          m_phase = PH_IDLE;
          r.action = ACT_REARM;
        end
        return 1'b1;
      end
      OP_ABORT: begin
        r.action = ACT_CANCEL;
        bulk_event_reply = (m_phase == PH_CARD);
        m_phase = PH_IDLE;
        m_aborting = 1'b1;
        m_seq = e.seq;
        return bulk_event_reply;
      end
      OP_RESP: begin
        if (m_aborting || m_phase != PH_CARD) return 1'b0;
        len = (e.len > LenW'(MaxPayload)) ? LenW'(MaxPayload) : e.len;
        err = (e.st == ST_HW) ? ERR_HW : ERR_UNSUPPORTED;
        cs = (e.st != ST_OK) ? CS_FAIL : CS_OK;
        case (m_req)
          RQ_POWER_OFF: r = build_msg(RT_SLOT, m_seq, ERR_UNSUPPORTED, cs, '0, 1'b0);
          RQ_GET, RQ_SET, RQ_RESET: begin
            if (cs == CS_FAIL) r = build_msg(RT_PARAMS, m_seq, err, CS_FAIL, '0, 1'b1);
            else r = build_msg(RT_PARAMS, m_seq, ERR_NONE, CS_OK, len, e.proto);
          end
          default: begin
            if (cs == CS_FAIL) r = build_msg(RT_DATA, m_seq, err, CS_FAIL, '0, 1'b0);
            else r = build_msg(RT_DATA, m_seq, ERR_NONE, CS_OK, len, 1'b0);
          end
        endcase
        return 1'b1;
      end
      OP_SUSPEND: begin
        m_phase = PH_IDLE;
        m_aborting = 1'b0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] seen);
    if (want !== seen) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    result_t seen, want;
    bit has;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        if (cfg_index == CFG_PACKET_SIZE) m_pkt = cfg_data;
        else m_icc = cfg_data[1:0];
      end
      // results are retired before new expectations are queued
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        n_results++;
        seen = {out_action, out_reply_type, out_reply_seq, out_reply_status, out_reply_error,
                out_reply_length, out_reply_protocol, out_request_kind, out_request_param};
        if (pending_replies.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result, expected none, actual action %0d",
                   $time, out_action);
        end else begin
          want = pending_replies.pop_front();
          cmp_field("action", 16'(want.action), 16'(seen.action));
          cmp_field("reply_type", 16'(want.reply_type), 16'(seen.reply_type));
          cmp_field("reply_seq", 16'(want.reply_seq), 16'(seen.reply_seq));
          cmp_field("reply_status", 16'(want.reply_status), 16'(seen.reply_status));
          cmp_field("reply_error", 16'(want.reply_error), 16'(seen.reply_error));
          cmp_field("reply_length", 16'(want.reply_length), 16'(seen.reply_length));
          cmp_field("reply_protocol", 16'(want.reply_protocol), 16'(seen.reply_protocol));
          cmp_field("request_kind", 16'(want.request_kind), 16'(seen.request_kind));
          cmp_field("request_param", 16'(want.request_param), 16'(seen.request_param));
          if (want.action == ACT_ZLP) n_zlp++;
          if (want.action == ACT_CANCEL) n_cancel++;
        end
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        n_items++;
        has = bulk_event_reply(cur_ev, want);
        if (has) pending_replies.push_back(row_typed ? row_want : want);
        if (has || cur_ev.op == OP_ABORT || cur_ev.op == OP_SUSPEND) n_eff++;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic push_event(input ccid_event_t e, input logic typed, input result_t want);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cur_ev <= e;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain all replies, then leave room for an event that gives no result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic ccid_event_t cmd_ev(input logic [7:0] mt, input logic [7:0] sq,
                                         input logic [7:0] pb);
    ccid_event_t e;
    e = '0;
    e.op = OP_CMD;
    e.mtype = mt;
    e.seq = sq;
    e.param = pb;
    return e;
  endfunction

  function automatic ccid_event_t resp_ev(input logic [1:0] st, input logic proto,
                                          input logic [LenW-1:0] len);
    ccid_event_t e;
    e = '0;
    e.op = OP_RESP;
    e.st = st;
    e.proto = proto;
    e.len = len;
    return e;
  endfunction

  function automatic ccid_event_t op_ev(input logic [2:0] op, input logic [7:0] sq);
    ccid_event_t e;
    e = '0;
    e.op = op;
    e.seq = sq;
    return e;
  endfunction

  function automatic ccid_event_t rand_ev();
    ccid_event_t e;
    e.op = 3'($urandom);
    e.mtype = 8'($urandom);
    e.seq = 8'($urandom);
    e.param = 8'($urandom);
    e.st = 2'($urandom);
    e.proto = 1'($urandom);
    e.len = LenW'($urandom);
    return e;
  endfunction

  function automatic logic [7:0] pick_msg_type();
    case ($urandom_range(0, 10))
      0:       return MT_POWER_ON;
      1:       return MT_POWER_OFF;
      2, 3:    return MT_XFR_BLOCK;
      4:       return MT_GET_PARAMS;
      5:       return MT_SET_PARAMS;
      6:       return MT_RESET_PARAMS;
      7:       return MT_SLOT_STATUS;
      8:       return MT_ABORT;
      default: return 8'($urandom);
    endcase
  endfunction

  // one host command carried through to the end of its transmit, mostly
  task automatic run_exchange();
    ccid_event_t e;
    logic [7:0] sq;
    int kmin, kmax;
    bit fwd;
    sq = 8'($urandom);
    e = rand_ev();
    e.op = OP_CMD;
    e.seq = sq;
    e.mtype = pick_msg_type();
    fwd = e.mtype inside {MT_POWER_ON, MT_POWER_OFF, MT_XFR_BLOCK, MT_GET_PARAMS,
                          MT_SET_PARAMS, MT_RESET_PARAMS};
    push_event(e, 1'b0, '0);
    if (fwd && $urandom_range(0, 7) == 0) begin
      e = rand_ev();
      e.op = OP_ABORT;
      e.seq = ($urandom_range(0, 3) != 0) ? sq : 8'($urandom);
      sq = e.seq;
      push_event(e, 1'b0, '0);
      if ($urandom_range(0, 1) == 0) begin
        e = rand_ev();
        e.op = OP_RESP;
        push_event(e, 1'b0, '0);
      end
      e = rand_ev();
      e.op = OP_CMD;
      e.seq = ($urandom_range(0, 3) != 0) ? sq : 8'($urandom);
      e.mtype = ($urandom_range(0, 3) != 0) ? MT_ABORT : pick_msg_type();
      push_event(e, 1'b0, '0);
    end else if (fwd) begin
      if ($urandom_range(0, 19) == 0) begin
        push_event(op_ev(OP_SUSPEND, 8'($urandom)), 1'b0, '0);
        return;
      end
      e = rand_ev();
      e.op = OP_RESP;
      e.st = ($urandom_range(0, 2) != 0) ? ST_OK : 2'($urandom_range(1, 3));
      case ($urandom_range(0, 4))
        0, 1: begin
          // land the message on a packet boundary
          if (cur_pkt != 0) begin
            kmin = (HdrLen + int'(cur_pkt) - 1) / int'(cur_pkt);
            kmax = (MaxPayload + HdrLen) / int'(cur_pkt);
            e.len = LenW'($urandom_range(kmin, kmax) * int'(cur_pkt) - HdrLen);
          end else begin
            e.len = LenW'($urandom_range(0, 200));
          end
        end
        2:       e.len = LenW'($urandom_range(0, 300));
        3:       e.len = LenW'($urandom_range(4080, 4100));
        default: ;
      endcase
      push_event(e, 1'b0, '0);
    end
    e = rand_ev();
    e.op = OP_TX_DONE;
    push_event(e, 1'b0, '0);
    if ($urandom_range(0, 4) != 0) push_event(e, 1'b0, '0);
  endtask

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int mode, stretch;
    mode = 0;
    stretch = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(8, 60);
        end
        stretch--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int target, ph;
    logic [6:0] pkt;
    logic [1:0] icc;
    ccid_event_t e;

    // directed events from reset, registers at their reset values
    dir_tab.push_back('{cmd_ev(MT_SLOT_STATUS, 8'h11, 8'h00), 1'b1,
                        '{ACT_SEND, RT_SLOT, 8'h11, 8'h01, ERR_NONE, 13'd0, 1'b0, 3'd0, 8'h00}});
    dir_tab.push_back('{op_ev(OP_TX_DONE, 8'h00), 1'b1, REARM_ONLY});
    // unknown message type, all ones
    dir_tab.push_back('{cmd_ev(8'hFF, 8'hFF, 8'hFF), 1'b1,
                        '{ACT_SEND, RT_SLOT, 8'hFF, 8'h41, ERR_NONE, 13'd0, 1'b0, 3'd0, 8'h00}});
    // command while a transmit is still open
    dir_tab.push_back('{cmd_ev(MT_POWER_ON, 8'h00, 8'h00), 1'b1, REARM_ONLY});
    dir_tab.push_back('{cmd_ev(MT_POWER_ON, 8'h01, 8'hFF), 1'b1,
                        '{ACT_FWD, RT_SLOT, 8'h00, 8'h00, ERR_NONE, 13'd0, 1'b0, RQ_POWER_ON,
                          8'hFF}});
    // oversized response length saturates
    dir_tab.push_back('{resp_ev(ST_OK, 1'b1, 13'h1FFF), 1'b1,
                        '{ACT_SEND, RT_DATA, 8'h01, 8'h01, ERR_NONE, 13'd4096, 1'b0, 3'd0,
                          8'h00}});
    dir_tab.push_back('{op_ev(OP_TX_DONE, 8'h00), 1'b0, '0});
    dir_tab.push_back('{cmd_ev(MT_XFR_BLOCK, 8'h02, 8'hA5), 1'b0, '0});
    dir_tab.push_back('{resp_ev(ST_HW, 1'b0, 13'd100), 1'b1,
                        '{ACT_SEND, RT_DATA, 8'h02, 8'h41, ERR_HW, 13'd0, 1'b0, 3'd0, 8'h00}});
    dir_tab.push_back('{op_ev(OP_TX_DONE, 8'h00), 1'b0, '0});
    dir_tab.push_back('{cmd_ev(MT_POWER_OFF, 8'h03, 8'h55), 1'b0, '0});
    dir_tab.push_back('{resp_ev(2'd2, 1'b0, 13'd20), 1'b0, '0});
    dir_tab.push_back('{op_ev(OP_TX_DONE, 8'h00), 1'b0, '0});
    dir_tab.push_back('{cmd_ev(MT_GET_PARAMS, 8'h04, 8'h00), 1'b0, '0});
    // 54 payload bytes plus header fill one 64-byte packet exactly
    dir_tab.push_back('{resp_ev(ST_OK, 1'b1, 13'd54), 1'b0, '0});
    dir_tab.push_back('{op_ev(OP_TX_DONE, 8'h00), 1'b1, ZLP_ONLY});
    dir_tab.push_back('{op_ev(OP_TX_DONE, 8'h00), 1'b0, '0});
    dir_tab.push_back('{cmd_ev(MT_SET_PARAMS, 8'h05, 8'h3C), 1'b0, '0});
    // status code 3 counts as an ordinary failure
    dir_tab.push_back('{resp_ev(2'd3, 1'b1, 13'd7), 1'b0, '0});
    dir_tab.push_back('{op_ev(OP_TX_DONE, 8'h00), 1'b0, '0});
    dir_tab.push_back('{cmd_ev(MT_RESET_PARAMS, 8'h06, 8'h00), 1'b0, '0});
    dir_tab.push_back('{op_ev(OP_ABORT, 8'h07), 1'b1, CANCEL_ONLY});
    // card answer during abort is dropped
    dir_tab.push_back('{resp_ev(ST_OK, 1'b0, 13'd5), 1'b0, '0});
    dir_tab.push_back('{cmd_ev(MT_SLOT_STATUS, 8'h07, 8'h00), 1'b1,
                        '{ACT_SEND, RT_SLOT, 8'h07, 8'h41, ERR_ABORTED, 13'd0, 1'b0, 3'd0,
                          8'h00}});
    dir_tab.push_back('{cmd_ev(MT_ABORT, 8'h07, 8'h00), 1'b0, '0});
    // abort with no card request open, then suspend clears it
    dir_tab.push_back('{op_ev(OP_ABORT, 8'h09), 1'b0, '0});
    dir_tab.push_back('{op_ev(OP_SUSPEND, 8'h00), 1'b0, '0});
    dir_tab.push_back('{op_ev(3'd7, 8'h00), 1'b0, '0});
    dir_tab.push_back('{op_ev(OP_TX_DONE, 8'h00), 1'b0, '0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) push_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);
    settle();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin pkt = 7'd64; icc = 2'd1; end
        1: begin pkt = 7'd8; icc = 2'd0; end
        2: begin pkt = 7'd0; icc = 2'd2; end
        3: begin pkt = 7'd127; icc = 2'd3; end
        default: begin
          pkt = 7'($urandom_range(8, 64));
          icc = 2'($urandom);
        end
      endcase
      cur_pkt = pkt;
      write_reg(CFG_PACKET_SIZE, pkt);
      write_reg(CFG_ICC_PRESENCE, {5'($urandom), icc});
      n_settings++;
      if (ph == 1) hold_go = 1'b1;
      target = n_eff + PHASE_ITEMS;
      while (n_eff < target) begin
        if ($urandom_range(0, 3) != 0) begin
          run_exchange();
        end else begin
          repeat ($urandom_range(1, 3)) begin
            e = rand_ev();
            e.op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            push_event(e, 1'b0, '0);
          end
        end
      end
      settle();
    end

    $display("covered %0d items and %0d results over %0d register settings",
             n_items, n_results, n_settings);
    $display("including %0d zero-length packets and %0d cancelled requests", n_zlp, n_cancel);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
